// ===== hdl/pst_pkg.sv =====
// Shared types, token kinds and constants for the Pascal subset tokenizer.
package pst_pkg;

  localparam int MaxIdentLength = 32;
  localparam int IdxW = $clog2(MaxIdentLength);
  localparam int LenW = $clog2(MaxIdentLength + 1);

  localparam logic [30:0] NumMax  = 31'h7FFF_FFFF;
  localparam logic [23:0] LineMax = 24'hFF_FFFF;

  typedef enum logic [4:0] {
    K_EOF = 5'd0, K_PROGRAM = 5'd1, K_VAR = 5'd2, K_BEGIN = 5'd3, K_END = 5'd4,
    K_INTEGER = 5'd5, K_BOOLEAN = 5'd6, K_TRUE = 5'd7, K_FALSE = 5'd8,
    K_IDENT = 5'd9, K_NUMBER = 5'd10, K_ASSIGN = 5'd11, K_COLON = 5'd12,
    K_SEMI = 5'd13, K_COMMA = 5'd14, K_PERIOD = 5'd15, K_PLUS = 5'd16,
    K_MINUS = 5'd17, K_STAR = 5'd18, K_SLASH = 5'd19, K_EQUAL = 5'd20,
    K_LESS = 5'd21, K_GREATER = 5'd22, K_UNKNOWN = 5'd23
  } kind_t;

  // Command from the scanner to the emitter
  typedef enum logic [1:0] {
    CMD_SINGLE = 2'd0,  // one result from the fields below
    CMD_IDENT  = 2'd1,  // drain the identifier buffer (or keyword)
    CMD_NONE   = 2'd2   // no result for this item
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    kind_t       kind;
    logic [30:0] value;
    logic [23:0] line;
    logic        ovf;
    logic        last_in;   // last command produced by this input
  } cmd_t;

  typedef struct packed {
    kind_t       token_kind;
    logic [30:0] number_value;
    logic [23:0] line_number;
    logic [7:0]  text_char;
    logic [4:0]  text_position;
    logic        last_of_token;
    logic        last_for_input;
    logic        overflowed;
  } result_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } item_t;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return c + 8'd32;
    return c;
  endfunction

  function automatic kind_t op_kind(logic [7:0] c);
    case (c)
      8'h3B: return K_SEMI;
      8'h2C: return K_COMMA;
      8'h2E: return K_PERIOD;
      8'h2B: return K_PLUS;
      8'h2D: return K_MINUS;
      8'h2A: return K_STAR;
      8'h2F: return K_SLASH;
      8'h3D: return K_EQUAL;
      8'h3C: return K_LESS;
      8'h3E: return K_GREATER;
      default: return K_UNKNOWN;
    endcase
  endfunction

  // Keyword character at position p (zero past the end)
  function automatic logic [7:0] kw_char(int k, int p);
    logic [7:0] w [8][7];
    w[0] = '{"p","r","o","g","r","a","m"};
    w[1] = '{"v","a","r",8'h0,8'h0,8'h0,8'h0};
    w[2] = '{"b","e","g","i","n",8'h0,8'h0};
    w[3] = '{"e","n","d",8'h0,8'h0,8'h0,8'h0};
    w[4] = '{"i","n","t","e","g","e","r"};
    w[5] = '{"b","o","o","l","e","a","n"};
    w[6] = '{"t","r","u","e",8'h0,8'h0,8'h0};
    w[7] = '{"f","a","l","s","e",8'h0,8'h0};
    if (p >= 7) return 8'h0;
    return w[k][p];
  endfunction

  function automatic int kw_len(int k);
    case (k)
      0, 4, 5: return 7;
      1, 3:    return 3;
      2, 7:    return 5;
      default: return 4;
    endcase
  endfunction

endpackage

// ===== hdl/pst_if.sv =====
// Valid/ready stream interface for tokenizer channels.
interface pst_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/pst_scan.sv =====
// Front end: classify bytes, track mode, lines, number and identifier.
module pst_scan import pst_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  item_t          in_item,
  // two commands may come from one byte: flush, then new token
  output logic           cmd_push,
  output cmd_t           cmd0,
  output logic           cmd1_en,
  output cmd_t           cmd1,
  input  logic [1:0]     q_free,
  // identifier buffer write port and snapshot to the back end
  output logic           buf_we,
  output logic [IdxW-1:0] buf_waddr,
  output logic [7:0]     buf_wdata,
  output logic [LenW-1:0] id_len,
  output logic           id_ovf,
  output logic [23:0]    id_line,
  input  logic           drain_busy
);

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001, M_COMMENT = 5'b00010, M_IDENT = 5'b00100,
    M_NUMBER = 5'b01000, M_COLON = 5'b10000
  } mode_t;

  mode_t         mode, mode_next;
  logic [LenW-1:0] ident_length, ident_length_next;
  logic [30:0]   number_accumulator, number_accumulator_next;
  logic [23:0]   line_counter, line_counter_next;
  logic [23:0]   token_start_line, token_start_line_next;
  logic          overflow_seen, overflow_seen_next;

  logic [7:0] c;
  logic is_ws, is_letter, is_digit, is_word;
  logic [34:0] prod;
  logic fire;
  cmd_t f_cmd, s_cmd;
  logic f_en, s_en;

  assign c = in_item.text_byte;
  assign is_ws = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  assign is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_digit = (c >= 8'h30 && c <= 8'h39);
  assign is_word = is_letter || is_digit || (c == 8'h5F);
  assign prod = {4'd0, number_accumulator} * 35'd10 + {31'd0, c[3:0]};

  // Stall while the emitter still reads the buffer, or the queue is short
  assign in_ready = (q_free == 2'd2) && !drain_busy;
  assign fire = in_valid && in_ready;

  always_comb begin
    mode_next = mode;
    ident_length_next = ident_length;
    number_accumulator_next = number_accumulator;
    line_counter_next = line_counter;
    token_start_line_next = token_start_line;
    overflow_seen_next = overflow_seen;
    buf_we = 1'b0;
    buf_waddr = '0;
    buf_wdata = c;
    f_en = 1'b0;
    s_en = 1'b0;
    f_cmd = '{op: CMD_SINGLE, kind: K_EOF, value: '0, line: token_start_line,
              ovf: 1'b0, last_in: 1'b0};
    s_cmd = '{op: CMD_SINGLE, kind: K_EOF, value: '0, line: line_counter,
              ovf: 1'b0, last_in: 1'b0};
    if (in_item.end_of_text) begin
      // flush pending token, then EOF
      unique case (mode)
        M_IDENT:  begin f_en = 1'b1; f_cmd.op = CMD_IDENT; end
        M_NUMBER: begin f_en = 1'b1; f_cmd.kind = K_NUMBER;
                        f_cmd.value = number_accumulator; f_cmd.ovf = overflow_seen; end
        M_COLON:  begin f_en = 1'b1; f_cmd.kind = K_COLON; end
        default:  ;
      endcase
      s_en = 1'b1;
      s_cmd.kind = K_EOF;
      line_counter_next = 24'd1;
      // keep the start line: the emitter still reads it while it drains the
      // flushed identifier, and every new token sets it again
      mode_next = M_IDLE;
    end else begin
      logic rescan;
      rescan = 1'b0;
      unique case (mode)
        M_COMMENT: begin
          if (c == 8'h7D) mode_next = M_IDLE;
          else if (c == 8'd10 && line_counter < LineMax)
            line_counter_next = line_counter + 24'd1;
        end
        M_IDENT: begin
          if (is_word) begin
            if (ident_length < LenW'(MaxIdentLength)) begin
              buf_we = fire;
              buf_waddr = ident_length[IdxW-1:0];
              ident_length_next = ident_length + 1'b1;
            end else overflow_seen_next = 1'b1;
          end else begin
            f_en = 1'b1; f_cmd.op = CMD_IDENT; rescan = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit) begin
            if (prod > {4'd0, NumMax}) begin
              number_accumulator_next = NumMax;
              overflow_seen_next = 1'b1;
            end else number_accumulator_next = prod[30:0];
          end else begin
            f_en = 1'b1; f_cmd.kind = K_NUMBER;
            f_cmd.value = number_accumulator; f_cmd.ovf = overflow_seen; rescan = 1'b1;
          end
        end
        M_COLON: begin
          if (c == 8'h3D) begin
            f_en = 1'b1; f_cmd.kind = K_ASSIGN; mode_next = M_IDLE;
          end else begin
            f_en = 1'b1; f_cmd.kind = K_COLON; rescan = 1'b1;
          end
        end
        default: rescan = 1'b1;
      endcase
      // Scan the byte from idle
      if (rescan) begin
        mode_next = M_IDLE;
        if (is_ws) begin
          if (c == 8'd10 && line_counter < LineMax)
            line_counter_next = line_counter + 24'd1;
        end else if (c == 8'h7B) begin
          mode_next = M_COMMENT;
        end else if (is_letter || c == 8'h5F) begin
          token_start_line_next = line_counter;
          buf_we = fire;
          buf_waddr = '0;
          ident_length_next = LenW'(1);
          overflow_seen_next = 1'b0;
          mode_next = M_IDENT;
        end else if (is_digit) begin
          token_start_line_next = line_counter;
          number_accumulator_next = {27'd0, c[3:0]};
          overflow_seen_next = 1'b0;
          mode_next = M_NUMBER;
        end else if (c == 8'h3A) begin
          token_start_line_next = line_counter;
          mode_next = M_COLON;
        end else begin
          token_start_line_next = line_counter;
          s_en = 1'b1;
          s_cmd.kind = op_kind(c);
        end
      end
    end
    // Pack commands; mark the last one of this input
    f_cmd.last_in = !s_en;
    s_cmd.last_in = 1'b1;
    if (!f_en && !s_en) begin
      cmd0 = '{op: CMD_NONE, kind: K_EOF, value: '0, line: '0, ovf: 1'b0, last_in: 1'b1};
      cmd1_en = 1'b0;
      cmd1 = s_cmd;
    end else if (f_en) begin
      cmd0 = f_cmd;
      cmd1_en = s_en;
      cmd1 = s_cmd;
    end else begin
      cmd0 = s_cmd;
      cmd1_en = 1'b0;
      cmd1 = s_cmd;
    end
  end

  // Push a command only for bytes that make results
  assign cmd_push = fire && (cmd0.op != CMD_NONE);
  assign id_len = ident_length;
  assign id_ovf = overflow_seen;
  assign id_line = token_start_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      ident_length <= '0;
      number_accumulator <= '0;
      line_counter <= 24'd1;
      token_start_line <= 24'd1;
      overflow_seen <= 1'b0;
    end else if (fire) begin
      mode <= mode_next;
      ident_length <= ident_length_next;
      number_accumulator <= number_accumulator_next;
      line_counter <= line_counter_next;
      token_start_line <= token_start_line_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

// ===== hdl/pst_queue.sv =====
// Two-entry command queue between the scanner and the emitter.
module pst_queue import pst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cmd_t       d0,
  input  logic       d1_en,
  input  cmd_t       d1,
  output logic [1:0] free,
  output logic       head_valid,
  output cmd_t       head,
  input  logic       pop
);

  cmd_t       slot [2];
  logic [1:0] count;

  assign head_valid = (count != 2'd0);
  assign head = slot[0];
  assign free = 2'd2 - count;

  // Shift on pop, append one or two commands on push (the scanner pushes only when empty)
  always_ff @(posedge clk) begin
    if (pop) slot[0] <= slot[1];
    if (push) begin
      if (count == 2'd0 || (count == 2'd1 && pop)) begin
        slot[0] <= d0;
        slot[1] <= d1;
      end else begin
        slot[1] <= d0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else count <= count - {1'b0, pop} + (push ? (d1_en ? 2'd2 : 2'd1) : 2'd0);
  end

endmodule

// ===== hdl/pst_emit.sv =====
// Back end: hold the identifier buffer, match keywords, emit result words.
module pst_emit import pst_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  cmd_t            head,
  output logic            pop,
  input  logic            buf_we,
  input  logic [IdxW-1:0] buf_waddr,
  input  logic [7:0]      buf_wdata,
  input  logic [LenW-1:0] id_len,
  input  logic            id_ovf,
  input  logic [23:0]     id_line,
  output logic            busy,
  output logic            out_valid,
  input  logic            out_ready,
  output result_t         out_data
);

  logic [7:0] ident_buffer [MaxIdentLength];
  logic [LenW-1:0] pos;
  logic [7:0] kw_hit;
  logic [7:0] ch;
  kind_t kw_kind;
  logic kw;
  logic slot_free, last_ch, adv;

  // Keyword match over the buffer (buffer entries past length not compared)
  always_comb begin
    kw_hit = '0;
    for (int k = 0; k < 8; k++) begin
      logic ok;
      ok = (id_len == LenW'(kw_len(k)));
      for (int p = 0; p < 7; p++)
        if (p < kw_len(k) && to_lower(ident_buffer[p]) != kw_char(k, p)) ok = 1'b0;
      kw_hit[k] = ok;
    end
    kw_kind = K_IDENT;
    for (int k = 7; k >= 0; k--)
      if (kw_hit[k]) kw_kind = kind_t'(5'(k + 1));
    kw = !id_ovf && (kw_kind != K_IDENT);
  end

  always_ff @(posedge clk) begin
    if (buf_we) ident_buffer[buf_waddr] <= buf_wdata;
  end

  assign ch = ident_buffer[pos[IdxW-1:0]];
  assign slot_free = !out_valid || out_ready;
  assign last_ch = (pos + 1'b1 == id_len);
  assign adv = head_valid && slot_free;
  assign pop = adv && (head.op != CMD_IDENT || kw || last_ch);
  assign busy = head_valid && head.op == CMD_IDENT;

  // Step through identifier characters one per cycle while the output slot is free
  always_ff @(posedge clk) begin
    if (rst) pos <= '0;
    else if (adv && head.op == CMD_IDENT && !kw) pos <= last_ch ? '0 : pos + 1'b1;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (slot_free) out_valid <= adv;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.line_number <= head.line;
      out_data.text_char <= '0;
      out_data.text_position <= '0;
      out_data.last_of_token <= 1'b1;
      out_data.last_for_input <= head.last_in;
      out_data.token_kind <= head.kind;
      out_data.number_value <= head.value;
      out_data.overflowed <= head.ovf;
      if (head.op == CMD_IDENT) begin
        out_data.line_number <= id_line;
        if (kw) begin
          out_data.token_kind <= kw_kind;
          out_data.number_value <= (kw_kind == K_TRUE) ? 31'd1 : 31'd0;
          out_data.overflowed <= 1'b0;
        end else begin
          out_data.token_kind <= K_IDENT;
          out_data.number_value <= '0;
          out_data.text_char <= ch;
          out_data.text_position <= pos[4:0];
          out_data.last_of_token <= last_ch;
          out_data.last_for_input <= head.last_in && last_ch;
          out_data.overflowed <= id_ovf;
        end
      end
    end
  end

endmodule

// ===== hdl/pascal_subset_tokenizer_core.sv =====
// Top level of the Pascal subset tokenizer.
//  channel | dir | payload
//  in_ch   | in  | text_byte[8], end_of_text[1]
//  out_ch  | out | token_kind .. overflowed (see result_t)
// Input waits until the two-entry command queue is empty and, when an
// identifier is flushed, until its characters have drained from the buffer.
// Reset (rst, synchronous) empties the queue and output register and restores
// line 1. Output stalls hold the word.
module pascal_subset_tokenizer_core import pst_pkg::*; (
  input logic clk,
  input logic rst,
  pst_if.sink   in_ch,
  pst_if.source out_ch
);

  logic cmd_push, cmd1_en, head_valid, pop, buf_we, id_ovf, busy;
  cmd_t cmd0, cmd1, head;
  logic [1:0] q_free;
  logic [IdxW-1:0] buf_waddr;
  logic [7:0] buf_wdata;
  logic [LenW-1:0] id_len;
  logic [23:0] id_line;
  item_t item;
  result_t res;

  assign item = in_ch.payload;
  assign out_ch.payload = res;

  pst_scan u_scan (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(item),
    .cmd_push, .cmd0, .cmd1_en, .cmd1, .q_free, .buf_we, .buf_waddr, .buf_wdata,
    .id_len, .id_ovf, .id_line, .drain_busy(busy)
  );

  pst_queue u_queue (
    .clk, .rst, .push(cmd_push), .d0(cmd0), .d1_en(cmd1_en), .d1(cmd1),
    .free(q_free), .head_valid, .head, .pop
  );

  pst_emit u_emit (
    .clk, .rst, .head_valid, .head, .pop, .buf_we, .buf_waddr, .buf_wdata,
    .id_len, .id_ovf, .id_line, .busy, .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_data(res)
  );

`ifndef ASSERT_OFF
  a_push_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> q_free == 2'd2) else $error("push into busy queue");
  a_no_write_drain: assert property (@(posedge clk) disable iff (rst)
    busy |-> !buf_we) else $error("buffer written while draining");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res))
    else $error("result dropped under stall");
`endif

endmodule
